### hdl/lru_slot_table_with_pinning_macros.svh
// Assertion macros for the LRU slot table with pinning.
// Used by the top level; depends on clk_i and rst_ni being in scope.
`ifndef LRU_SLOT_TABLE_WITH_PINNING_MACROS_SVH
`define LRU_SLOT_TABLE_WITH_PINNING_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LSTP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LSTP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/lstp_pkg.sv
// Shared constants for the LRU slot table with pinning.
// No dependencies; imported by the top level.
package lstp_pkg;

  localparam int SLOTS_DEF    = 64;
  localparam int KEY_BITS_DEF = 32;

  localparam int OP_W    = 4;
  localparam int SLOT_W  = 6;
  localparam int KEY_W   = 32;
  localparam int COUNT_W = 32;
  localparam int STAMP_W = 32;
  localparam int CFG_W   = 7;
  localparam int MODE_W  = 2;
  localparam int TOTAL_W = 7;

  localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

  localparam logic [MODE_W-1:0] MODE_FREE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PINNED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_USED   = 2'd2;

  localparam logic [OP_W-1:0] OP_INSERT      = 4'd0;
  localparam logic [OP_W-1:0] OP_CLEAN       = 4'd1;
  localparam logic [OP_W-1:0] OP_TOUCH       = 4'd2;
  localparam logic [OP_W-1:0] OP_PIN         = 4'd3;
  localparam logic [OP_W-1:0] OP_UNPIN       = 4'd4;
  localparam logic [OP_W-1:0] OP_FIND_FREE   = 4'd5;
  localparam logic [OP_W-1:0] OP_FIND_VICTIM = 4'd6;
  localparam logic [OP_W-1:0] OP_READ        = 4'd7;
  localparam logic [OP_W-1:0] OP_COUNT_INC   = 4'd8;
  localparam logic [OP_W-1:0] OP_COUNT_SET   = 4'd9;

  typedef enum logic [4:0] {
    ST_CLR  = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_READ = 5'b01000,
    ST_EXEC = 5'b10000
  } state_e;

endpackage

### hdl/lru_slot_table_with_pinning.sv
// Top level of the LRU slot table with pinning: slot store, sequencer and result register.
// Depends on lstp_pkg and lru_slot_table_with_pinning_macros.svh.
`include "lru_slot_table_with_pinning_macros.svh"

// All slot state (mode, key, access stamp, use counter) lives in one single-port-read
// memory with a registered read. After reset a clearing pass writes every entry to zero,
// during which no word is accepted; the size register can be written at any time. A word
// that addresses one slot goes through read, then modify, write back and present the
// result. Free-slot and victim searches read one slot per cycle through the same port.
// One word is in flight at a time; a finished result waits in the output register while
// the next word is accepted.
module lru_slot_table_with_pinning
  import lstp_pkg::*;
#(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OP_W-1:0]     op_i,
  input  logic [SLOT_W-1:0]   slot_i,
  input  logic [KEY_W-1:0]    key_i,
  input  logic [COUNT_W-1:0]  count_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                status_o,
  output logic [SLOT_W-1:0]   found_slot_o,
  output logic [KEY_W-1:0]    key_out_o,
  output logic [MODE_W-1:0]   slot_state_o,
  output logic [COUNT_W-1:0]  count_out_o,
  output logic [TOTAL_W-1:0]  pinned_total_o,
  output logic                all_pinned_o
);

  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int NW      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int KW      = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int CNT_LO  = 0;
  localparam int STP_LO  = CNT_LO + COUNT_W;
  localparam int KEY_LO  = STP_LO + STAMP_W;
  localparam int MODE_LO = KEY_LO + KW;
  localparam int EW      = MODE_LO + MODE_W;

  logic [EW-1:0] mem_q [SLOTS];
  logic [EW-1:0] rdata_q;
  logic          mem_we;
  logic [IDX_W-1:0] mem_wa, mem_ra;
  logic [EW-1:0]    mem_wd;

  state_e state_q, state_d;
  logic [CFG_W-1:0]   cfg_q;
  logic [OP_W-1:0]    op_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [KW-1:0]      key_q;
  logic [COUNT_W-1:0] cval_q;
  logic [NW-1:0]      ptr_q, ptr_d;
  logic [NW-1:0]      chk_idx_q, chk_idx_d;
  logic               chk_q, chk_d;
  logic               hit_q, hit_d;
  logic [NW-1:0]      hit_idx_q, hit_idx_d;
  logic [STAMP_W-1:0] best_q, best_d;
  logic [NW-1:0]      rep_q, rep_d;
  logic               scan_err_q, scan_err_d;
  logic [NW-1:0]      pinned_q, pinned_d;
  logic [STAMP_W-1:0] now_q, now_d;

  logic               out_valid_q;
  logic               status_q;
  logic [SLOT_W-1:0]  found_q;
  logic [KEY_W-1:0]   key_out_q;
  logic [MODE_W-1:0]  mode_out_q;
  logic [COUNT_W-1:0] count_out_q;
  logic [TOTAL_W-1:0] total_q;
  logic               all_pinned_q;

  logic [NW-1:0]      n_eff;
  logic               accept, is_search, scan_issue, scan_done, exec_go;
  logic [MODE_W-1:0]  e_mode, w_mode;
  logic [KW-1:0]      e_key, w_key;
  logic [STAMP_W-1:0] e_stamp, w_stamp;
  logic [COUNT_W-1:0] e_count, w_count;
  logic               rep_ok, x_err, x_wr, x_stamp;
  logic [NW-1:0]      x_pinned;

  assign n_eff = (NW'(cfg_q) < NW'(SLOTS)) ? NW'(cfg_q) : NW'(SLOTS);

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign is_search  = (op_i == OP_FIND_FREE) || (op_i == OP_FIND_VICTIM);
  assign scan_issue = (ptr_q < n_eff);
  assign exec_go    = (state_q == ST_EXEC) && !(out_valid_q && out_stall_i);

  assign e_mode  = rdata_q[MODE_LO +: MODE_W];
  assign e_key   = rdata_q[KEY_LO +: KW];
  assign e_stamp = rdata_q[STP_LO +: STAMP_W];
  assign e_count = rdata_q[CNT_LO +: COUNT_W];

  // Slot store with registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rdata_q <= mem_q[mem_ra];
  end

  assign mem_ra = (state_q == ST_SCAN) ? ptr_q[IDX_W-1:0] : rep_q[IDX_W-1:0];
  assign mem_wa = (state_q == ST_CLR) ? ptr_q[IDX_W-1:0] : rep_q[IDX_W-1:0];
  assign mem_we = (state_q == ST_CLR) || (exec_go && x_wr);
  assign mem_wd = (state_q == ST_CLR) ? '0 : {w_mode, w_key, w_stamp, w_count};

  // Search step on the entry returned from the previous read.
  always_comb begin
    hit_d     = hit_q;
    hit_idx_d = hit_idx_q;
    best_d    = best_q;
    if (state_q == ST_SCAN && chk_q) begin
      if (op_q == OP_FIND_FREE) begin
        if (e_mode == MODE_FREE && !hit_q) begin
          hit_d     = 1'b1;
          hit_idx_d = chk_idx_q;
        end
      end else if (e_mode == MODE_USED && (!hit_q || e_stamp < best_q)) begin
        hit_d     = 1'b1;
        hit_idx_d = chk_idx_q;
        best_d    = e_stamp;
      end
    end
    scan_done = ((op_q == OP_FIND_FREE) && hit_d) || (!scan_issue && !chk_q);
  end

  // Read-modify-write of the reported slot.
  always_comb begin
    rep_ok   = (rep_q < n_eff);
    w_mode   = e_mode;
    w_key    = e_key;
    w_stamp  = e_stamp;
    w_count  = e_count;
    x_err    = 1'b0;
    x_wr     = 1'b0;
    x_stamp  = 1'b0;
    x_pinned = pinned_q;
    case (op_q)
      OP_INSERT: begin
        if (!rep_ok || e_mode == MODE_PINNED) begin
          x_err = 1'b1;
        end else begin
          w_mode  = MODE_USED;
          w_key   = key_q;
          w_stamp = now_q;
          x_wr    = 1'b1;
          x_stamp = 1'b1;
        end
      end
      OP_CLEAN: begin
        if (!rep_ok) begin
          x_err = 1'b1;
        end else begin
          if (e_mode == MODE_PINNED && pinned_q != '0) begin
            x_pinned = pinned_q - NW'(1);
          end
          w_mode = MODE_FREE;
          w_key  = '0;
          x_wr   = 1'b1;
        end
      end
      OP_TOUCH: begin
        if (!rep_ok) begin
          x_err = 1'b1;
        end else begin
          w_stamp = now_q;
          x_wr    = 1'b1;
          x_stamp = 1'b1;
        end
      end
      OP_PIN: begin
        if (!rep_ok || e_mode != MODE_USED) begin
          x_err = 1'b1;
        end else begin
          w_mode   = MODE_PINNED;
          x_pinned = pinned_q + NW'(1);
          x_wr     = 1'b1;
        end
      end
      OP_UNPIN: begin
        if (!rep_ok || e_mode != MODE_PINNED) begin
          x_err = 1'b1;
        end else begin
          w_mode = MODE_USED;
          if (pinned_q != '0) begin
            x_pinned = pinned_q - NW'(1);
          end
          x_wr = 1'b1;
        end
      end
      OP_FIND_FREE, OP_FIND_VICTIM: begin
        x_err = scan_err_q;
      end
      OP_READ: begin
        x_err = !rep_ok;
      end
      OP_COUNT_INC: begin
        if (!rep_ok) begin
          x_err = 1'b1;
        end else begin
          w_count = e_count + COUNT_W'(1);
          x_wr    = 1'b1;
        end
      end
      OP_COUNT_SET: begin
        if (!rep_ok) begin
          x_err = 1'b1;
        end else begin
          w_count = cval_q;
          x_wr    = 1'b1;
        end
      end
      default: begin
        x_err = 1'b1;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    chk_d      = 1'b0;
    chk_idx_d  = ptr_q;
    rep_d      = rep_q;
    scan_err_d = scan_err_q;
    pinned_d   = pinned_q;
    now_d      = now_q;
    case (state_q)
      ST_CLR: begin
        ptr_d = ptr_q + NW'(1);
        if (ptr_q == NW'(SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          ptr_d      = '0;
          rep_d      = NW'(slot_i);
          scan_err_d = 1'b0;
          state_d    = is_search ? ST_SCAN : ST_READ;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          rep_d      = hit_d ? hit_idx_d : NW'(slot_q);
          scan_err_d = !hit_d;
          state_d    = ST_READ;
        end else if (scan_issue) begin
          ptr_d = ptr_q + NW'(1);
          chk_d = 1'b1;
        end
      end
      ST_READ: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_go) begin
          pinned_d = x_pinned;
          if (x_stamp && now_q != '1) begin
            now_d = now_q + STAMP_W'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      cfg_q       <= SIZE_RESET;
      ptr_q       <= '0;
      chk_q       <= 1'b0;
      hit_q       <= 1'b0;
      scan_err_q  <= 1'b0;
      pinned_q    <= '0;
      now_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      chk_q      <= chk_d;
      scan_err_q <= scan_err_d;
      pinned_q   <= pinned_d;
      now_q      <= now_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (accept) begin
        hit_q <= 1'b0;
      end else begin
        hit_q <= hit_d;
      end
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= chk_idx_d;
    hit_idx_q <= hit_idx_d;
    best_q    <= best_d;
    rep_q     <= rep_d;
    if (accept) begin
      op_q   <= op_i;
      slot_q <= slot_i;
      key_q  <= key_i[KW-1:0];
      cval_q <= count_value_i;
    end
    if (exec_go) begin
      status_q     <= x_err;
      found_q      <= rep_q[SLOT_W-1:0];
      key_out_q    <= rep_ok ? KEY_W'(w_key) : '0;
      mode_out_q   <= rep_ok ? w_mode : MODE_FREE;
      count_out_q  <= rep_ok ? w_count : '0;
      total_q      <= TOTAL_W'(x_pinned);
      all_pinned_q <= (x_pinned >= n_eff);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign found_slot_o   = found_q;
  assign key_out_o      = key_out_q;
  assign slot_state_o   = mode_out_q;
  assign count_out_o    = count_out_q;
  assign pinned_total_o = total_q;
  assign all_pinned_o   = all_pinned_q;

  `LSTP_ASSERT_NOW(a_pinned_bound, 1'b1, pinned_q <= NW'(SLOTS), "pin count too high")
  `LSTP_ASSERT_NOW(a_write_phase, mem_we, state_q == ST_CLR || state_q == ST_EXEC, "stray write")
  `LSTP_ASSERT_NEXT(a_result_once, exec_go, state_q == ST_IDLE && out_valid_q, "result missing")

endmodule

### sim/lru_slot_table_with_pinning_tb.sv
// Testbench for lru_slot_table_with_pinning: a shadow copy of the slot table predicts each
// result, and random stalls sit on both handshakes. Needs lstp_pkg and the block's RTL.
`timescale 1ns / 100ps

module lru_slot_table_with_pinning_tb;
  import lstp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYCLES = 80;

  typedef struct packed {
    logic               status;
    logic [SLOT_W-1:0]  found;
    logic [KEY_W-1:0]   key;
    logic [MODE_W-1:0]  mode;
    logic [COUNT_W-1:0] count;
    logic [TOTAL_W-1:0] pinned;
    logic               all_pinned;
  } table_result_t;

  class slot_table_shadow;
    logic [MODE_W-1:0]  mode_mem  [SLOTS_DEF];
    logic [KEY_W-1:0]   key_mem   [SLOTS_DEF];
    logic [STAMP_W-1:0] stamp_mem [SLOTS_DEF];
    logic [COUNT_W-1:0] count_mem [SLOTS_DEF];
    int unsigned        pinned_cnt;
    logic [STAMP_W-1:0] clock_now;
    logic [CFG_W-1:0]   size_reg;
    table_result_t      pending_results [$];
    int unsigned        errors;

    function new();
      for (int i = 0; i < SLOTS_DEF; i++) begin
        mode_mem[i] = MODE_FREE;
        key_mem[i] = '0;
        stamp_mem[i] = '0;
        count_mem[i] = '0;
      end
      pinned_cnt = 0;
      clock_now = '0;
      size_reg = SIZE_RESET;
      errors = 0;
    endfunction

    function void restamp(int unsigned s);
      stamp_mem[s] = clock_now;
      if (clock_now != '1) clock_now = clock_now + 1'b1;
    endfunction

    function void apply_word(logic [OP_W-1:0] op, logic [SLOT_W-1:0] s,
                             logic [KEY_W-1:0] key, logic [COUNT_W-1:0] cval);
      int unsigned n;
      int unsigned rep;
      int hit;
      bit in_range;
      bit err;
      logic [STAMP_W-1:0] oldest;
      table_result_t r;
      n = (32'(size_reg) < SLOTS_DEF) ? 32'(size_reg) : SLOTS_DEF;
      in_range = 32'(s) < n;
      err = 1'b0;
      rep = 32'(s);
      hit = -1;
      oldest = '0;
      case (op)
        OP_INSERT: begin
          if (!in_range || mode_mem[s] == MODE_PINNED) begin
            err = 1'b1;
          end else begin
            mode_mem[s] = MODE_USED;
            key_mem[s] = key;
            restamp(s);
          end
        end
        OP_CLEAN: begin
          if (!in_range) begin
            err = 1'b1;
          end else begin
            if (mode_mem[s] == MODE_PINNED && pinned_cnt > 0) pinned_cnt--;
            mode_mem[s] = MODE_FREE;
            key_mem[s] = '0;
          end
        end
        OP_TOUCH: begin
          if (!in_range) err = 1'b1;
          else restamp(s);
        end
        OP_PIN: begin
          if (!in_range || mode_mem[s] != MODE_USED) begin
            err = 1'b1;
          end else begin
            mode_mem[s] = MODE_PINNED;
            pinned_cnt++;
          end
        end
        OP_UNPIN: begin
          if (!in_range || mode_mem[s] != MODE_PINNED) begin
            err = 1'b1;
          end else begin
            mode_mem[s] = MODE_USED;
            if (pinned_cnt > 0) pinned_cnt--;
          end
        end
        OP_FIND_FREE: begin
          for (int i = 0; i < n; i++) begin
            if (hit < 0 && mode_mem[i] == MODE_FREE) hit = i;
          end
          if (hit < 0) err = 1'b1;
          else rep = hit;
        end
        OP_FIND_VICTIM: begin
          for (int i = 0; i < n; i++) begin
            if (mode_mem[i] == MODE_USED && (hit < 0 || stamp_mem[i] < oldest)) begin
              hit = i;
              oldest = stamp_mem[i];
            end
          end
          if (hit < 0) err = 1'b1;
          else rep = hit;
        end
        OP_READ: begin
          if (!in_range) err = 1'b1;
        end
        OP_COUNT_INC: begin
          if (!in_range) err = 1'b1;
          else count_mem[s] = count_mem[s] + 1'b1;
        end
        OP_COUNT_SET: begin
          if (!in_range) err = 1'b1;
          else count_mem[s] = cval;
        end
        default: begin
          err = 1'b1;
        end
      endcase
      r.status = err;
      r.found = rep[SLOT_W-1:0];
      if (rep < n) begin
        r.key = key_mem[rep[SLOT_W-1:0]];
        r.mode = mode_mem[rep[SLOT_W-1:0]];
        r.count = count_mem[rep[SLOT_W-1:0]];
      end else begin
        r.key = '0;
        r.mode = MODE_FREE;
        r.count = '0;
      end
      r.pinned = pinned_cnt[TOTAL_W-1:0];
      r.all_pinned = pinned_cnt >= n;
      pending_results.push_back(r);
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("%0t: mismatch in %s: got %h, expected %h", $realtime, field, got, want);
    endtask

    task compare_result(table_result_t got);
      table_result_t want;
      if (pending_results.size() == 0) begin
        report("result with no word pending", 32'd0, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) report("status", got.status, want.status);
        if (got.found !== want.found) report("found_slot", got.found, want.found);
        if (got.key !== want.key) report("key_out", got.key, want.key);
        if (got.mode !== want.mode) report("slot_state", got.mode, want.mode);
        if (got.count !== want.count) report("count_out", got.count, want.count);
        if (got.pinned !== want.pinned) report("pinned_total", got.pinned, want.pinned);
        if (got.all_pinned !== want.all_pinned) begin
          report("all_pinned", got.all_pinned, want.all_pinned);
        end
      end
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CFG_W-1:0]   cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [OP_W-1:0]    op_i;
  logic [SLOT_W-1:0]  slot_i;
  logic [KEY_W-1:0]   key_i;
  logic [COUNT_W-1:0] count_value_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               status_o;
  logic [SLOT_W-1:0]  found_slot_o;
  logic [KEY_W-1:0]   key_out_o;
  logic [MODE_W-1:0]  slot_state_o;
  logic [COUNT_W-1:0] count_out_o;
  logic [TOTAL_W-1:0] pinned_total_o;
  logic               all_pinned_o;

  slot_table_shadow shadow;
  bit in_steady;
  bit out_steady;
  int unsigned cycles;

  lru_slot_table_with_pinning dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .slot_i         (slot_i),
    .key_i          (key_i),
    .count_value_i  (count_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .found_slot_o   (found_slot_o),
    .key_out_o      (key_out_o),
    .slot_state_o   (slot_state_o),
    .count_out_o    (count_out_o),
    .pinned_total_o (pinned_total_o),
    .all_pinned_o   (all_pinned_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_word(logic [OP_W-1:0] op, logic [SLOT_W-1:0] s,
                           logic [KEY_W-1:0] key, logic [COUNT_W-1:0] cval);
    int unsigned gap;
    gap = in_steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    slot_i <= s;
    key_i <= key;
    count_value_i <= cval;
    do @(posedge clk_i); while (in_stall_o);
    shadow.apply_word(op, s, key, cval);
  endtask

  task automatic random_word(int unsigned n);
    int unsigned pick;
    logic [OP_W-1:0] op;
    logic [SLOT_W-1:0] s;
    logic [COUNT_W-1:0] cval;
    pick = $urandom_range(0, 99);
    if (pick < 22) op = OP_INSERT;
    else if (pick < 30) op = OP_CLEAN;
    else if (pick < 40) op = OP_TOUCH;
    else if (pick < 50) op = OP_PIN;
    else if (pick < 58) op = OP_UNPIN;
    else if (pick < 66) op = OP_FIND_FREE;
    else if (pick < 76) op = OP_FIND_VICTIM;
    else if (pick < 84) op = OP_READ;
    else if (pick < 90) op = OP_COUNT_INC;
    else if (pick < 96) op = OP_COUNT_SET;
    else op = OP_W'($urandom_range(10, 15));
    if (n != 0 && $urandom_range(0, 9) != 0) s = SLOT_W'($urandom_range(0, n - 1));
    else s = SLOT_W'($urandom_range(0, SLOTS_DEF - 1));
    case ($urandom_range(0, 7))
      0: cval = '1;
      1: cval = '0;
      default: cval = $urandom;
    endcase
    send_word(op, s, $urandom, cval);
  endtask

  task automatic wait_drained(int unsigned settle);
    in_valid_i <= 1'b0;
    while (shadow.pending_results.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_size(logic [CFG_W-1:0] value);
    cfg_wdata_i <= value;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    shadow.size_reg = value;
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    table_result_t got;
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      hold = out_steady ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got.status = status_o;
      got.found = found_slot_o;
      got.key = key_out_o;
      got.mode = slot_state_o;
      got.count = count_out_o;
      got.pinned = pinned_total_o;
      got.all_pinned = all_pinned_o;
      shadow.compare_result(got);
    end
  end

  initial begin
    logic [CFG_W-1:0] sizes [10];
    int unsigned n;
    int unsigned items;
    shadow = new();
    sizes = '{7'd127, 7'd1, 7'd2, 7'd5, 7'd0, 7'd17, 7'd64, 7'd33, 7'd3, 7'd64};
    cycles = 0;
    in_steady = 1'b0;
    out_steady = 1'b0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    op_i <= OP_READ;
    slot_i <= '0;
    key_i <= '0;
    count_value_i <= '0;
    out_stall_i <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words at the reset size, then a few at a size of two to reach the edges.
    send_word(OP_READ, 6'd0, '0, '0);
    send_word(OP_FIND_FREE, 6'd7, '0, '0);
    send_word(OP_FIND_VICTIM, 6'd5, '0, '0);
    send_word(OP_INSERT, 6'd0, 32'hFFFF_FFFF, '0);
    send_word(OP_INSERT, 6'd63, 32'h0000_0000, '1);
    send_word(OP_PIN, 6'd0, '0, '0);
    send_word(OP_PIN, 6'd0, '0, '0);
    send_word(OP_INSERT, 6'd0, 32'h1234_5678, '0);
    send_word(OP_PIN, 6'd1, '0, '0);
    send_word(OP_UNPIN, 6'd2, '0, '0);
    send_word(OP_FIND_VICTIM, 6'd0, '0, '0);
    send_word(OP_COUNT_SET, 6'd63, '0, 32'hFFFF_FFFF);
    send_word(OP_COUNT_INC, 6'd63, '0, '0);
    send_word(OP_UNPIN, 6'd0, '0, '0);
    send_word(OP_TOUCH, 6'd0, '0, '0);
    send_word(OP_FIND_VICTIM, 6'd9, '0, '0);
    send_word(OP_CLEAN, 6'd63, '0, '0);
    send_word(4'd10, 6'd4, '0, '0);
    send_word(4'd15, 6'd63, '1, '1);
    wait_drained(8);
    write_size(7'd2);
    send_word(OP_INSERT, 6'd5, 32'hA5A5_A5A5, '0);
    send_word(OP_READ, 6'd63, '0, '0);
    send_word(OP_INSERT, 6'd1, 32'h5A5A_5A5A, '0);
    send_word(OP_PIN, 6'd0, '0, '0);
    send_word(OP_PIN, 6'd1, '0, '0);
    send_word(OP_FIND_FREE, 6'd3, '0, '0);
    send_word(OP_CLEAN, 6'd1, '0, '0);
    wait_drained(8);

    for (int p = 0; p < 10; p++) begin
      in_steady = (p % 3) == 1;
      out_steady = (p % 4) == 1;
      write_size(sizes[p]);
      n = (32'(sizes[p]) < SLOTS_DEF) ? 32'(sizes[p]) : SLOTS_DEF;
      items = (n == 0) ? 30 : 160;
      for (int i = 0; i < items; i++) random_word(n);
      wait_drained(8);
    end

    wait_drained(SETTLE_CYCLES);
    if (shadow.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
